// ----- design/fcs_pkg.sv -----
package fcs_pkg;

  // default table size and fixed field widths
  localparam int unsigned DefTableDepth = 16;
  localparam int unsigned CodeW         = 16;
  localparam int unsigned WeightW       = 8;
  localparam int unsigned TotalW        = 12;
  localparam int unsigned CountOutW     = 5;
  localparam int unsigned IndexW        = 4;
  localparam int unsigned OpW           = 2;

  // register reset values
  localparam logic [CodeW-1:0]   MisfireLowRst    = 16'd300;
  localparam logic [CodeW-1:0]   MisfireHighRst   = 16'd312;
  localparam logic [WeightW-1:0] MisfireWeightRst = 8'd5;

  // configuration register byte addresses
  localparam int unsigned        PaddrW          = 4;
  localparam logic [PaddrW-1:0]  AddrMisfireLow  = 4'h0;
  localparam logic [PaddrW-1:0]  AddrMisfireHigh = 4'h4;
  localparam logic [PaddrW-1:0]  AddrMisfireWt   = 4'h8;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } status_t;

  // severity of one code under the current misfire range
  function automatic logic [WeightW-1:0] weight_of(input logic [CodeW-1:0] code,
                                                  input logic [CodeW-1:0] low,
                                                  input logic [CodeW-1:0] high,
                                                  input logic [WeightW-1:0] weight);
    logic [WeightW-1:0] w;
    w = '0;
    if (code >= low && code <= high) w = weight;
    return w;
  endfunction

  // saturating accumulate of the severity total
  function automatic logic [TotalW-1:0] sat_add(input logic [TotalW-1:0] total,
                                                input logic [WeightW-1:0] w);
    logic [TotalW:0] sum;
    sum = {1'b0, total} + (TotalW+1)'(w);
    return sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];
  endfunction

endpackage

// ----- design/fcs_ctrl.sv -----
module fcs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fcs_pkg::cmd_t   cmd_o,
  input  fcs_pkg::status_t stat_i
);
  import fcs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // result register can take a new result
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (stat_i.scan_done) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.start  = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/fcs_datapath.sv -----
module fcs_datapath #(
  parameter int unsigned TABLE_DEPTH = fcs_pkg::DefTableDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fcs_pkg::cmd_t                 cmd_i,
  output fcs_pkg::status_t              stat_o,
  input  logic [fcs_pkg::OpW-1:0]       op_i,
  input  logic [fcs_pkg::CodeW-1:0]     fault_code_i,
  input  logic [fcs_pkg::IndexW-1:0]    read_index_i,
  input  logic [fcs_pkg::CodeW-1:0]     misfire_low_i,
  input  logic [fcs_pkg::CodeW-1:0]     misfire_high_i,
  input  logic [fcs_pkg::WeightW-1:0]   misfire_weight_i,
  output logic [fcs_pkg::CountOutW-1:0] code_count_o,
  output logic                          has_codes_o,
  output logic                          changed_o,
  output logic [fcs_pkg::TotalW-1:0]    severity_total_o,
  output logic [fcs_pkg::CodeW-1:0]     entry_code_o
);
  import fcs_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // code table
  logic [CodeW-1:0] mem_q [TABLE_DEPTH];
  logic [CodeW-1:0] rdata_q;

  // item registers
  op_e               op_q;
  logic [CodeW-1:0]  code_q;
  logic [IndexW-1:0] ridx_q;

  // scan control
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;
  logic            pv_q;
  logic [IdxW-1:0] pidx_q;
  logic            issue;

  // accumulated scan results
  logic              found_q, found_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [CodeW-1:0]  entry_q, entry_d;
  logic              match;
  logic              shift_we;
  logic              append, removed, changed_n;

  // result register
  logic [CountOutW-1:0] res_count_q;
  logic                 res_has_q;
  logic                 res_changed_q;
  logic [TotalW-1:0]    res_total_q;
  logic [CodeW-1:0]     res_entry_q;

  // memory write port
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [CodeW-1:0] mem_wdata;

  // one table read per cycle while entries remain
  assign issue = cmd_i.scan && (rd_ptr_q < count_q);
  assign stat_o.scan_done = (rd_ptr_q >= count_q) && !pv_q;
  assign match = pv_q && (rdata_q == code_q);

  // finish decisions
  assign append  = (op_q == OP_ADD) && !found_q && (count_q < CntW'(TABLE_DEPTH));
  assign removed = (op_q == OP_REMOVE) && found_q;
  assign changed_n = append || removed || ((op_q == OP_CLEAR) && (count_q != '0));

  // start clearing, per-entry processing and finishing step
  always_comb begin
    total_d  = total_q;
    found_d  = found_q;
    entry_d  = entry_q;
    shift_we = 1'b0;
    count_d  = count_q;
    if (cmd_i.start) begin
      total_d = '0;
      found_d = 1'b0;
      entry_d = '0;
    end else if (pv_q) begin
      if (match) found_d = 1'b1;
      if (!((op_q == OP_REMOVE) && match)) begin
        total_d = sat_add(total_q,
                          weight_of(rdata_q, misfire_low_i, misfire_high_i, misfire_weight_i));
      end
      // entries after the removed code move one place down
      if ((op_q == OP_REMOVE) && found_q) shift_we = 1'b1;
      if ((op_q == OP_READ) && (32'(pidx_q) == 32'(ridx_q))) entry_d = rdata_q;
    end else if (cmd_i.finish) begin
      if (append) begin
        total_d = sat_add(total_q,
                          weight_of(code_q, misfire_low_i, misfire_high_i, misfire_weight_i));
        count_d = count_q + CntW'(1);
      end
      if (removed) count_d = count_q - CntW'(1);
      if (op_q == OP_CLEAR) begin
        total_d = '0;
        count_d = '0;
      end
    end
  end

  // read pointer
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    if (cmd_i.start) rd_ptr_d = '0;
    else if (issue) rd_ptr_d = rd_ptr_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_ptr_q <= '0;
      pv_q     <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      pv_q     <= issue;
    end
  end

  // item and scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= op_e'(op_i);
      code_q <= fault_code_i;
      ridx_q <= read_index_i;
    end
    pidx_q  <= rd_ptr_q[IdxW-1:0];
    found_q <= found_d;
    total_q <= total_d;
    entry_q <= entry_d;
  end

  // table write: shift during remove, append at finish
  assign mem_we    = shift_we || (cmd_i.finish && append);
  assign mem_waddr = shift_we ? (pidx_q - IdxW'(1)) : count_q[IdxW-1:0];
  assign mem_wdata = shift_we ? rdata_q : code_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (issue) rdata_q <= mem_q[rd_ptr_q[IdxW-1:0]];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_count_q   <= (32'(count_d) > 32'd31) ? {CountOutW{1'b1}} : CountOutW'(count_d);
      res_has_q     <= (count_d != '0);
      res_changed_q <= changed_n;
      res_total_q   <= total_d;
      res_entry_q   <= entry_q;
    end
  end

  assign code_count_o     = res_count_q;
  assign has_codes_o      = res_has_q;
  assign changed_o        = res_changed_q;
  assign severity_total_o = res_total_q;
  assign entry_code_o     = res_entry_q;

endmodule

// ----- design/fault_code_set_with_severity.sv -----
// Ordered set of distinct fault codes with a misfire severity total.
// Input channel s_axis: one operation per transfer (add, remove, clear, read).
// Output channel m_axis: exactly one result per operation, in order, with the
// code count, a nonzero flag, a changed flag, the severity total and, for a
// read, the entry at the requested position.
// Configuration: APB port with the misfire range low/high and the weight
// at byte addresses 0x0, 0x4 and 0x8; write them only while no operation
// is in flight.
// Timing: one operation is handled at a time. The stored codes are scanned
// through the single registered read port of the table, one entry per
// cycle, and a new operation is taken only after the result of the last
// one has been written to the output register.
// Reset clears the stored count and returns the registers to 300, 312 and 5;
// the table contents are never read beyond the count, so no clearing pass.
// If the receiver stalls, the result is held in the output register; the
// block finishes the scan of the next operation and then waits for it.
module fault_code_set_with_severity #(
  parameter int unsigned TABLE_DEPTH = fcs_pkg::DefTableDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // tdata: op[1:0], fault_code[17:2], read_index[21:18], zero fill [23:22]
  input  logic [23:0]                s_axis_tdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: code_count[4:0], has_codes[5], changed[6], severity_total[18:7],
  //        entry_code[34:19], zero fill [39:35]
  output logic [39:0]                m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fcs_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import fcs_pkg::*;

  fcs_pkg::cmd_t    cmd;
  fcs_pkg::status_t stat;

  logic [CodeW-1:0]   mis_low_q, mis_high_q;
  logic [WeightW-1:0] mis_weight_q;
  logic               cfg_we;

  logic [CountOutW-1:0] code_count;
  logic                 has_codes, changed;
  logic [TotalW-1:0]    severity_total;
  logic [CodeW-1:0]     entry_code;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mis_low_q    <= MisfireLowRst;
      mis_high_q   <= MisfireHighRst;
      mis_weight_q <= MisfireWeightRst;
    end else if (cfg_we) begin
      unique case (paddr)
        AddrMisfireLow:  mis_low_q    <= pwdata[CodeW-1:0];
        AddrMisfireHigh: mis_high_q   <= pwdata[CodeW-1:0];
        AddrMisfireWt:   mis_weight_q <= pwdata[WeightW-1:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (paddr)
      AddrMisfireLow:  prdata = 32'(mis_low_q);
      AddrMisfireHigh: prdata = 32'(mis_high_q);
      AddrMisfireWt:   prdata = 32'(mis_weight_q);
      default:         prdata = '0;
    endcase
  end

  fcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  fcs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .op_i             (s_axis_tdata[1:0]),
    .fault_code_i     (s_axis_tdata[17:2]),
    .read_index_i     (s_axis_tdata[21:18]),
    .misfire_low_i    (mis_low_q),
    .misfire_high_i   (mis_high_q),
    .misfire_weight_i (mis_weight_q),
    .code_count_o     (code_count),
    .has_codes_o      (has_codes),
    .changed_o        (changed),
    .severity_total_o (severity_total),
    .entry_code_o     (entry_code)
  );

  // result packing
  assign m_axis_tdata = {5'b0, entry_code, severity_total, changed, has_codes, code_count};

`ifndef NO_ASSERTIONS
  // one operation at a time: no new transfer right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an operation is in progress");

  // count never exceeds the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(code_count) <= TABLE_DEPTH))
    else $error("code count beyond table depth");

  // nonzero flag follows the count
  a_has_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (has_codes == (code_count != '0)))
    else $error("has_codes disagrees with code_count");

  // an empty set has no severity
  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (code_count == '0)) |-> (severity_total == '0))
    else $error("severity total nonzero on an empty set");
`endif

endmodule

// ----- verif/fcs_checker.sv -----
`timescale 1ns / 100ps

module fcs_checker #(
  parameter int unsigned DEPTH = fcs_pkg::DefTableDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [23:0]                s_axis_tdata,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [39:0]                m_axis_tdata,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fcs_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  output int                         mismatches,
  output int                         results_due_cnt,
  output int                         results_seen,
  output int                         set_changes
);
  import fcs_pkg::*;

  // result layout, highest field first so it maps straight onto tdata[34:0]
  typedef struct packed {
    logic [CodeW-1:0]     entry_code;
    logic [TotalW-1:0]    severity_total;
    logic                 changed;
    logic                 has_codes;
    logic [CountOutW-1:0] code_count;
  } fault_result_t;

  // own copy of the fault table and the misfire registers
  logic [CodeW-1:0]   fault_table [DEPTH];
  int unsigned        fault_cnt;
  logic [CodeW-1:0]   mf_low;
  logic [CodeW-1:0]   mf_high;
  logic [WeightW-1:0] mf_weight;

  fault_result_t results_due[$];

  // apply one operation to the table copy and work out its result
  function automatic fault_result_t apply_fault_op(input op_e op, input logic [CodeW-1:0] code,
                                                   input logic [IndexW-1:0] idx);
    fault_result_t res;
    int            pos;
    int unsigned   total;
    res = '0;
    pos = -1;
    for (int i = 0; i < fault_cnt; i++)
      if (pos < 0 && fault_table[i] == code) pos = i;
    case (op)
      OP_ADD: begin
        if (fault_cnt < DEPTH && pos < 0) begin
          fault_table[fault_cnt] = code;
          fault_cnt++;
          res.changed = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos >= 0) begin
          for (int i = pos; i + 1 < fault_cnt; i++) fault_table[i] = fault_table[i+1];
          fault_cnt--;
          fault_table[fault_cnt] = '0;
          res.changed = 1'b1;
        end
      end
      OP_CLEAR: begin
        res.changed = (fault_cnt != 0);
        for (int i = 0; i < DEPTH; i++) fault_table[i] = '0;
        fault_cnt = 0;
      end
      default: begin
        if (idx < fault_cnt) res.entry_code = fault_table[idx];
      end
    endcase
    // misfire severity over the stored codes, saturating
    total = 0;
    for (int i = 0; i < fault_cnt; i++) begin
      if (fault_table[i] >= mf_low && fault_table[i] <= mf_high) total += mf_weight;
      if (total > 4095) total = 4095;
    end
    res.severity_total = total[TotalW-1:0];
    res.code_count     = (fault_cnt > 31) ? 5'd31 : fault_cnt[CountOutW-1:0];
    res.has_codes      = (fault_cnt != 0);
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    fault_result_t exp_r;
    fault_result_t act_r;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) fault_table[i] = '0;
      fault_cnt = 0;
      mf_low    = MisfireLowRst;
      mf_high   = MisfireHighRst;
      mf_weight = MisfireWeightRst;
      results_due.delete();
    end else begin
      // result transfer against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        act_r = fault_result_t'(m_axis_tdata[34:0]);
        if (results_due.size() == 0) begin
          $error("result transfer with no operation outstanding: %h", m_axis_tdata);
          mismatches++;
        end else begin
          exp_r = results_due.pop_front();
          results_seen++;
          check_field("code_count", exp_r.code_count, act_r.code_count);
          check_field("has_codes", exp_r.has_codes, act_r.has_codes);
          check_field("changed", exp_r.changed, act_r.changed);
          check_field("severity_total", exp_r.severity_total, act_r.severity_total);
          check_field("entry_code", exp_r.entry_code, act_r.entry_code);
        end
      end
      // operation transfer
      if (s_axis_tvalid && s_axis_tready) begin
        exp_r = apply_fault_op(op_e'(s_axis_tdata[1:0]), s_axis_tdata[17:2],
                               s_axis_tdata[21:18]);
        if (exp_r.changed) set_changes++;
        results_due.push_back(exp_r);
      end
      // register writes and read-back
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr)
            AddrMisfireLow:  mf_low    = pwdata[CodeW-1:0];
            AddrMisfireHigh: mf_high   = pwdata[CodeW-1:0];
            AddrMisfireWt:   mf_weight = pwdata[WeightW-1:0];
            default: ;
          endcase
        end else begin
          case (paddr)
            AddrMisfireLow:  check_field("misfire_code_low", mf_low, prdata);
            AddrMisfireHigh: check_field("misfire_code_high", mf_high, prdata);
            AddrMisfireWt:   check_field("misfire_weight", mf_weight, prdata);
            default: ;
          endcase
        end
      end
    end
    results_due_cnt = results_due.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import fcs_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned PhaseItems = 200;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  // tdata: op[1:0], fault_code[17:2], read_index[21:18], zero fill [23:22]
  logic [23:0]       s_axis_tdata  = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // tdata: code_count[4:0], has_codes[5], changed[6], severity_total[18:7],
  //        entry_code[34:19], zero fill [39:35]
  logic [39:0]       m_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [PaddrW-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  int mismatches;
  int results_due_cnt;
  int results_seen;
  int set_changes;
  int ops_sent    = 0;
  int settings    = 0;
  int hold_cnt    = 0;
  int cycle_cnt   = 0;
  bit tx_burst    = 1'b0;
  bit rx_burst    = 1'b0;

  fault_code_set_with_severity u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  fcs_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .results_due_cnt(results_due_cnt),
    .results_seen   (results_seen),
    .set_changes    (set_changes)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt, results_due_cnt);
    $display("tb: FAIL");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(negedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (rst_ni && !rx_burst && $urandom_range(0, 3) == 0) begin
      hold_cnt      <= gap_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // one operation transfer; called and returns at a falling edge
  task automatic send_op(input op_e op, input logic [CodeW-1:0] code,
                         input logic [IndexW-1:0] idx);
    int gap;
    gap = tx_burst ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {2'b00, idx, code, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    ops_sent++;
    @(negedge clk_i);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (results_due_cnt != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // apb setup and access cycle, leaves psel high for a following transfer
  task automatic apb_access(input logic wr, input logic [PaddrW-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  // program the misfire range and weight, then read all three back
  task automatic set_misfire(input logic [CodeW-1:0] low, input logic [CodeW-1:0] high,
                             input logic [WeightW-1:0] weight);
    apb_access(1'b1, AddrMisfireLow, {16'h0, low});
    apb_access(1'b1, AddrMisfireHigh, {16'h0, high});
    apb_access(1'b1, AddrMisfireWt, {24'h0, weight});
    apb_access(1'b0, AddrMisfireLow, '0);
    apb_access(1'b0, AddrMisfireHigh, '0);
    apb_access(1'b0, AddrMisfireWt, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [CodeW-1:0]   lows    [6];
    logic [CodeW-1:0]   highs   [6];
    logic [WeightW-1:0] weights [6];
    logic [CodeW-1:0]   pool_base;
    logic [CodeW-1:0]   code;
    op_e                op;
    int                 r;

    // full range at top weight, empty range, zero weight, top corner,
    // reset values and one random setting
    lows    = '{16'd0,     16'd100, 16'd1000, 16'd65530, 16'd300, 16'd0};
    highs   = '{16'd65535, 16'd50,  16'd1010, 16'd65535, 16'd312, 16'd0};
    weights = '{8'd255,    8'd7,    8'd0,     8'd1,      8'd5,    8'd0};
    lows[5]    = 16'($urandom_range(0, 65000));
    highs[5]   = 16'(lows[5] + $urandom_range(0, 30));
    weights[5] = 8'($urandom_range(1, 254));

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers come out of reset at their defaults
    apb_access(1'b0, AddrMisfireLow, '0);
    apb_access(1'b0, AddrMisfireHigh, '0);
    apb_access(1'b0, AddrMisfireWt, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);

    // directed: empty table, range edges, duplicates, full table, clear
    send_op(OP_READ, 16'h0, 4'd0);
    send_op(OP_CLEAR, 16'h0, 4'd0);
    send_op(OP_ADD, 16'd300, 4'd0);
    send_op(OP_ADD, 16'd312, 4'd0);
    send_op(OP_ADD, 16'd313, 4'd0);
    send_op(OP_ADD, 16'h0000, 4'd0);
    send_op(OP_ADD, 16'hFFFF, 4'd0);
    send_op(OP_ADD, 16'd300, 4'd0);
    send_op(OP_READ, 16'h0, 4'd15);
    send_op(OP_REMOVE, 16'd312, 4'd0);
    send_op(OP_REMOVE, 16'd4321, 4'd0);
    for (int i = 0; i < 12; i++) send_op(OP_ADD, 16'(301 + i), 4'd0);
    send_op(OP_ADD, 16'd299, 4'd0);
    send_op(OP_READ, 16'h0, 4'd15);
    send_op(OP_REMOVE, 16'd300, 4'd0);
    send_op(OP_CLEAR, 16'h0, 4'd0);

    // random phases, one misfire setting each
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      set_misfire(lows[ph], highs[ph], weights[ph]);
      @(negedge clk_i);
      pool_base = lows[ph] - 16'd6;
      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 40 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        // codes mostly from a small pool around the misfire range, so that
        // duplicates, removals of stored codes and a full table all occur
        code = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                           : 16'(pool_base + $urandom_range(0, 23));
        r    = $urandom_range(0, 99);
        op   = (r < 45) ? OP_ADD : (r < 75) ? OP_REMOVE : (r < 97) ? OP_READ : OP_CLEAR;
        send_op(op, code, 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end

    drain_results();
    repeat (30) @(negedge clk_i);
    $display("tb: %0d operations, %0d results checked, %0d of them altered the set",
             ops_sent, results_seen, set_changes);
    $display("tb: %0d misfire settings incl. full range, empty range and zero weight",
             settings);
    if (mismatches == 0 && results_due_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/fcs_pkg.sv
design/fcs_ctrl.sv
design/fcs_datapath.sv
design/fault_code_set_with_severity.sv
verif/fcs_checker.sv
verif/tb.sv
